// ===== rtl/rsof_pkg.sv =====
// rsof_pkg: shared types and constants of the range sample outlier filter
// word layouts of the three channels, register indexes, reset values, unit ops
// no dependencies
`default_nettype none

package rsof_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned AccW    = 32;
  localparam int unsigned FracW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] CfgFilterMode  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSmoothWeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgJumpLimit   = 2'd2;

  // register reset values
  localparam logic               ResetMode   = 1'b0;
  localparam logic [SampleW-1:0] ResetWeight = 16'd6554;
  localparam logic [SampleW-1:0] ResetLimit  = 16'd200;

  // filter mode codes
  localparam logic ModeWindow = 1'b0;
  localparam logic ModeSmooth = 1'b1;

  // input word: one sensor poll
  typedef struct packed {
    logic [SampleW-1:0] reading;
    logic               reading_ready;
    logic               timed_out;
  } in_item_t;

  // output word: filter state after the poll
  typedef struct packed {
    logic [SampleW-1:0] filtered_value;
    logic [SampleW-1:0] last_raw;
    logic               fresh_sample;
    logic               status_ok;
  } out_item_t;

  // configuration write word
  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [SampleW-1:0] data;
  } cfg_word_t;

  // shared arithmetic unit operations
  typedef enum logic [1:0] {
    AluAbsDiff,
    AluAdd,
    AluSub
  } alu_op_e;

endpackage

`default_nettype wire

// ===== rtl/rsof_chan_if.sv =====
// rsof_chan_if: valid/ready channel carrying one word of a given type
// used for the input, output and configuration channels; no dependencies
`default_nettype none

interface rsof_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/range_sample_outlier_filter.sv =====
// range_sample_outlier_filter: poll filter for a distance sensor
// input channel in_ch_i takes one poll word (reading, reading_ready, timed_out)
// output channel out_ch_o gives one word per poll (filtered_value, last_raw,
// fresh_sample, status_ok); cfg_ch_i writes filter_mode (0), smoothing_weight
// (1) and jump_limit (2), always ready, other indexes ignored
// a poll that does not run the filter goes from idle straight to the finish step
// window mode: the ring is walked one entry a cycle through the shared
// abs-difference unit; a last step accepts the sample or holds the old value
// smoothing mode: difference, 32x16 multiply and accumulate steps, then finish
// in_ch_i.ready is high only between polls; one poll is worked at a time
// the output word sits in a register, so the next poll is taken while it
// waits; a stalled receiver holds the block in its last step until taken
// reset clears the ring's written flags, pointers, accumulator and held
// values and loads the register reset values; no clearing pass is needed
// depends on rsof_pkg, rsof_chan_if, rsof_ring, rsof_alu
`default_nettype none

module range_sample_outlier_filter #(
  parameter int unsigned RING_DEPTH = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rsof_chan_if.sink   in_ch_i,
  rsof_chan_if.source out_ch_o,
  rsof_chan_if.sink   cfg_ch_i
);

  localparam int unsigned PtrW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned SW   = rsof_pkg::SampleW;
  localparam int unsigned AW   = rsof_pkg::AccW;
  localparam int unsigned FW   = rsof_pkg::FracW;

  typedef enum logic [2:0] {
    StIdle,
    StWalk,
    StWalkLast,
    StSmDiff,
    StSmMul,
    StSmAcc,
    StFinish
  } state_e;

  state_e              state_q;
  logic                mode_q;
  logic [SW-1:0]       weight_q;
  logic [SW-1:0]       limit_q;
  logic [PtrW-1:0]     ptr_q;
  logic [PtrW-1:0]     cnt_q;
  logic                chk_q;
  logic                reject_q;
  logic [SW-1:0]       accepted_q;
  logic [AW-1:0]       acc_q;
  logic [SW-1:0]       outv_q;
  logic [SW-1:0]       raw_q;
  logic [SW-1:0]       sample_q;
  logic                fresh_q;
  logic                ok_q;
  logic [AW-1:0]       dmag_q;
  logic                up_q;
  logic [AW-1:0]       step_q;
  logic                out_vld_q;
  rsof_pkg::out_item_t out_pl_q;

  rsof_pkg::in_item_t  in_w;
  rsof_pkg::cfg_word_t cfg_w;
  logic                in_acc;
  logic                in_fresh;
  logic                in_run;
  logic [PtrW-1:0]     ptr_nxt;
  logic [SW-1:0]       rd_data;
  rsof_pkg::alu_op_e   alu_op;
  logic [AW-1:0]       alu_a;
  logic [AW-1:0]       alu_b;
  logic [AW-1:0]       alu_res;
  logic                alu_ge;
  logic                fail;
  logic [AW+FW-1:0]    prod;
  logic                out_free;

  assign in_w   = in_ch_i.payload;
  assign cfg_w  = cfg_ch_i.payload;

  // handshakes
  assign in_ch_i.ready  = (state_q == StIdle);
  assign cfg_ch_i.ready = 1'b1;
  assign in_acc         = in_ch_i.valid & in_ch_i.ready;
  assign out_free       = ~out_vld_q | out_ch_o.ready;

  assign out_ch_o.valid   = out_vld_q;
  assign out_ch_o.payload = out_pl_q;

  // poll classification
  assign in_fresh = in_w.reading_ready & (in_w.reading != '0);
  assign in_run   = in_fresh & ~in_w.timed_out;

  // ring pointer advance, wraps at the depth
  assign ptr_nxt = (ptr_q == PtrW'(RING_DEPTH - 1)) ? '0 : ptr_q + PtrW'(1);

  rsof_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_acc & in_run & (mode_q == rsof_pkg::ModeWindow)),
    .wr_addr_i (ptr_nxt),
    .wr_data_i (in_w.reading),
    .rd_addr_i (cnt_q),
    .rd_data_o (rd_data)
  );

  // operand select for the shared unit
  always_comb begin
    alu_op = rsof_pkg::AluAbsDiff;
    alu_a  = '0;
    alu_b  = '0;
    case (state_q)
      StWalk, StWalkLast: begin
        alu_a = {{(AW-SW){1'b0}}, rd_data};
        alu_b = {{(AW-SW){1'b0}}, accepted_q};
      end
      StSmDiff: begin
        alu_a = {sample_q, {FW{1'b0}}};
        alu_b = acc_q;
      end
      StSmAcc: begin
        alu_op = up_q ? rsof_pkg::AluAdd : rsof_pkg::AluSub;
        alu_a  = acc_q;
        alu_b  = step_q;
      end
      default: begin
        alu_op = rsof_pkg::AluAbsDiff;
      end
    endcase
  end

  rsof_alu u_alu (
    .op_i     (alu_op),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .res_o    (alu_res),
    .a_ge_b_o (alu_ge)
  );

  // ring entry too far from the accepted value
  assign fail = chk_q & (alu_res > {{(AW-SW){1'b0}}, limit_q});

  // smoothing step product, weight is a Q0.16 fraction
  assign prod = (AW+FW)'(dmag_q) * (AW+FW)'(weight_q);

  // sequencer, configuration and held state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      mode_q     <= rsof_pkg::ResetMode;
      weight_q   <= rsof_pkg::ResetWeight;
      limit_q    <= rsof_pkg::ResetLimit;
      ptr_q      <= '0;
      cnt_q      <= '0;
      chk_q      <= 1'b0;
      reject_q   <= 1'b0;
      accepted_q <= '0;
      acc_q      <= '0;
      outv_q     <= '0;
      raw_q      <= '0;
      sample_q   <= '0;
      fresh_q    <= 1'b0;
      ok_q       <= 1'b1;
      dmag_q     <= '0;
      up_q       <= 1'b0;
      step_q     <= '0;
      out_vld_q  <= 1'b0;
      out_pl_q   <= '0;
    end else begin
      // configuration writes
      if (cfg_ch_i.valid) begin
        case (cfg_w.index)
          rsof_pkg::CfgFilterMode:   mode_q   <= cfg_w.data[0];
          rsof_pkg::CfgSmoothWeight: weight_q <= cfg_w.data;
          rsof_pkg::CfgJumpLimit:    limit_q  <= cfg_w.data;
          default: ;
        endcase
      end

      // output word taken, unless the finish step loads the next one
      if (out_vld_q && out_ch_o.ready && (state_q != StFinish)) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (in_w.reading_ready) begin
              raw_q <= in_w.reading;
            end
            sample_q <= in_w.reading;
            fresh_q  <= in_fresh;
            ok_q     <= ~(in_fresh & in_w.timed_out);
            if (!in_run) begin
              state_q <= StFinish;
            end else if (mode_q == rsof_pkg::ModeSmooth) begin
              state_q <= StSmDiff;
            end else begin
              ptr_q    <= ptr_nxt;
              cnt_q    <= '0;
              chk_q    <= 1'b0;
              reject_q <= 1'b0;
              state_q  <= StWalk;
            end
          end
        end
        StWalk: begin
          if (fail) begin
            reject_q <= 1'b1;
          end
          chk_q <= 1'b1;
          if (cnt_q == PtrW'(RING_DEPTH - 1)) begin
            state_q <= StWalkLast;
          end else begin
            cnt_q <= cnt_q + PtrW'(1);
          end
        end
        StWalkLast: begin
          if (reject_q || fail) begin
            outv_q <= accepted_q;
          end else begin
            accepted_q <= sample_q;
            outv_q     <= sample_q;
          end
          state_q <= StFinish;
        end
        StSmDiff: begin
          dmag_q  <= alu_res;
          up_q    <= alu_ge;
          state_q <= StSmMul;
        end
        StSmMul: begin
          step_q  <= prod[AW+FW-1:FW];
          state_q <= StSmAcc;
        end
        StSmAcc: begin
          acc_q   <= alu_res;
          outv_q  <= alu_res[AW-1:AW-SW];
          state_q <= StFinish;
        end
        StFinish: begin
          if (out_free) begin
            out_vld_q               <= 1'b1;
            out_pl_q.filtered_value <= outv_q;
            out_pl_q.last_raw       <= raw_q;
            out_pl_q.fresh_sample   <= fresh_q;
            out_pl_q.status_ok      <= ok_q;
            state_q                 <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // a waiting output word is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish && out_vld_q && !out_ch_o.ready) |=> (state_q == StFinish))
    else $error("output word overwritten while stalled");

  // ring pointer and walk counter stay inside the ring
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(ptr_q) < RING_DEPTH) && (32'(cnt_q) < RING_DEPTH))
    else $error("ring index out of range");

  // a poll that does not run the filter leaves the filtered value alone
  a_hold_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_run) |=> ##1 $stable(outv_q))
    else $error("filtered value changed without a fresh sample");

  // smoothing never overshoots the largest target
  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= {{SW{1'b1}}, {FW{1'b0}}})
    else $error("accumulator above largest target");

  // the ring check ends with an accept or a hold of the old value
  a_walk_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalkLast) |=> (outv_q == accepted_q))
    else $error("window result differs from accepted value");

endmodule

`default_nettype wire

// ===== rtl/rsof_ring.sv =====
// rsof_ring: ring of recent readings, one write and one registered read port
// entries never written since reset read as zero; uses rsof_pkg
`default_nettype none

module rsof_ring #(
  parameter int unsigned RING_DEPTH = 8,
  localparam int unsigned PtrW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [PtrW-1:0]               wr_addr_i,
  input  wire logic [rsof_pkg::SampleW-1:0]  wr_data_i,
  input  wire logic [PtrW-1:0]               rd_addr_i,
  output logic      [rsof_pkg::SampleW-1:0]  rd_data_o
);

  logic [rsof_pkg::SampleW-1:0] mem_q [RING_DEPTH];
  logic [RING_DEPTH-1:0]        vld_q;
  logic [rsof_pkg::SampleW-1:0] rd_data_q;
  logic                         rd_vld_q;

  // storage array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  // per-entry written flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ===== rtl/rsof_alu.sv =====
// rsof_alu: shared 32-bit add, subtract and absolute difference unit
// serves both the ring walk and the smoothing update; uses rsof_pkg
`default_nettype none

module rsof_alu (
  input  wire rsof_pkg::alu_op_e           op_i,
  input  wire logic [rsof_pkg::AccW-1:0]   a_i,
  input  wire logic [rsof_pkg::AccW-1:0]   b_i,
  output logic      [rsof_pkg::AccW-1:0]   res_o,
  output logic                             a_ge_b_o
);

  logic [rsof_pkg::AccW:0]   diff;
  logic [rsof_pkg::AccW-1:0] rdiff;
  logic [rsof_pkg::AccW-1:0] sum;

  // one borrow chain gives ordering, the other the reversed difference
  assign diff     = {1'b0, a_i} - {1'b0, b_i};
  assign rdiff    = b_i - a_i;
  assign sum      = a_i + b_i;
  assign a_ge_b_o = ~diff[rsof_pkg::AccW];

  always_comb begin
    case (op_i)
      rsof_pkg::AluAbsDiff: res_o = a_ge_b_o ? diff[rsof_pkg::AccW-1:0] : rdiff;
      rsof_pkg::AluAdd:     res_o = sum;
      rsof_pkg::AluSub:     res_o = diff[rsof_pkg::AccW-1:0];
      default:              res_o = '0;
    endcase
  end

endmodule

`default_nettype wire
